@@ src/frg_pkg.sv @@
// frg_pkg: shared constants, types and helpers for the fraction reducer
// used by frg_div, frg_dp, frg_ctrl and fraction_reduce_gcd; no dependencies
`default_nettype none

package frg_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned CntW  = $clog2(Width);

  typedef logic [Width-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EUC_RUN,
    ST_NUM_RUN,
    ST_DEN_RUN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SRC_EUCLID,
    SRC_NUMER,
    SRC_DENOM
  } div_src_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_src_e div_src;
    logic     step;
    logic     store_qn;
    logic     store_qd;
  } cmd_t;

  typedef struct packed {
    logic both_zero;
    logic b_zero;
    logic div_done;
  } status_t;

  function automatic word_t mag_of(input word_t v);
    return v[Width-1] ? (~v + word_t'(1)) : v;
  endfunction

  function automatic word_t join_of(input logic neg, input word_t mag);
    return neg ? (~mag + word_t'(1)) : mag;
  endfunction

endpackage

`default_nettype wire

@@ src/frg_div.sv @@
// frg_div: restoring unsigned divider, one quotient bit per cycle
// depends on frg_pkg
`default_nettype none

module frg_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire frg_pkg::word_t dividend_i,
  input  wire frg_pkg::word_t divisor_i,
  output logic               done_o,
  output frg_pkg::word_t     quo_o,
  output frg_pkg::word_t     rem_o
);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [frg_pkg::CntW-1:0] cnt_q, cnt_d;
  frg_pkg::word_t           rem_q, rem_d;
  frg_pkg::word_t           quo_q, quo_d;
  frg_pkg::word_t           dvs_q, dvs_d;
  logic [frg_pkg::Width:0]  trial;

  assign trial = {rem_q, quo_q[frg_pkg::Width-1]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = frg_pkg::CntW'(frg_pkg::Width - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[frg_pkg::Width]) begin
        rem_d = trial[frg_pkg::Width-1:0];
        quo_d = {quo_q[frg_pkg::Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[frg_pkg::Width-2:0], quo_q[frg_pkg::Width-1]};
        quo_d = {quo_q[frg_pkg::Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - frg_pkg::CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ src/frg_dp.sv @@
// frg_dp: operand registers, euclid swap logic and output sign handling
// depends on frg_pkg and frg_div
`default_nettype none

module frg_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire frg_pkg::cmd_t  cmd_i,
  input  wire frg_pkg::word_t numer_in_i,
  input  wire frg_pkg::word_t denom_in_i,
  output frg_pkg::status_t    status_o,
  output frg_pkg::word_t      numer_out_o,
  output frg_pkg::word_t      denom_out_o,
  output logic                zero_over_zero_o
);

  logic           ns_q, ds_q, as_q, bs_q;
  frg_pkg::word_t nm_q, dm_q, am_q, bm_q, qn_q, qd_q;
  logic           zz_q;
  frg_pkg::word_t nm_in, dm_in;
  frg_pkg::word_t div_dividend, div_divisor, div_quo, div_rem;
  logic           div_done;
  logic           sn, sd;

  assign nm_in = frg_pkg::mag_of(numer_in_i);
  assign dm_in = frg_pkg::mag_of(denom_in_i);

  always_comb begin
    unique case (cmd_i.div_src)
      frg_pkg::SRC_EUCLID: begin
        div_dividend = am_q;
        div_divisor  = bm_q;
      end
      frg_pkg::SRC_NUMER: begin
        div_dividend = nm_q;
        div_divisor  = am_q;
      end
      frg_pkg::SRC_DENOM: begin
        div_dividend = dm_q;
        div_divisor  = am_q;
      end
      default: begin
        div_dividend = am_q;
        div_divisor  = bm_q;
      end
    endcase
  end

  frg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ns_q <= numer_in_i[frg_pkg::Width-1];
      ds_q <= denom_in_i[frg_pkg::Width-1];
      nm_q <= nm_in;
      dm_q <= dm_in;
      as_q <= numer_in_i[frg_pkg::Width-1];
      bs_q <= denom_in_i[frg_pkg::Width-1];
      am_q <= nm_in;
      bm_q <= dm_in;
      zz_q <= (nm_in == '0) && (dm_in == '0);
    end else if (cmd_i.step) begin
      // remainder keeps the sign of the dividend
      as_q <= bs_q;
      bs_q <= as_q;
      am_q <= bm_q;
      bm_q <= div_rem;
    end
    if (cmd_i.store_qn) qn_q <= div_quo;
    if (cmd_i.store_qd) qd_q <= div_quo;
  end

  assign sn = (qn_q != '0) ? (ns_q ^ as_q) : 1'b0;
  assign sd = (qd_q != '0) ? (ds_q ^ as_q) : 1'b0;

  assign numer_out_o      = zz_q ? '0 : frg_pkg::join_of(sn, qn_q);
  assign denom_out_o      = zz_q ? '0 : frg_pkg::join_of(sd, qd_q);
  assign zero_over_zero_o = zz_q;

  assign status_o.both_zero = zz_q;
  assign status_o.b_zero    = (bm_q == '0);
  assign status_o.div_done  = div_done;

endmodule

`default_nettype wire

@@ src/frg_ctrl.sv @@
// frg_ctrl: sequencer for euclid steps and the two final divisions
// depends on frg_pkg
`default_nettype none

module frg_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  output logic                  valid_o,
  output frg_pkg::cmd_t         cmd_o,
  input  wire frg_pkg::status_t status_i
);

  frg_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frg_pkg::ST_IDLE: begin
        if (start) state_d = frg_pkg::ST_CHECK;
      end
      frg_pkg::ST_CHECK: begin
        if (status_i.both_zero) state_d = frg_pkg::ST_DONE;
        else if (status_i.b_zero) state_d = frg_pkg::ST_NUM_RUN;
        else state_d = frg_pkg::ST_EUC_RUN;
      end
      frg_pkg::ST_EUC_RUN: begin
        if (status_i.div_done) state_d = frg_pkg::ST_CHECK;
      end
      frg_pkg::ST_NUM_RUN: begin
        if (status_i.div_done) state_d = frg_pkg::ST_DEN_RUN;
      end
      frg_pkg::ST_DEN_RUN: begin
        if (status_i.div_done) state_d = frg_pkg::ST_DONE;
      end
      frg_pkg::ST_DONE: begin
        state_d = frg_pkg::ST_IDLE;
      end
      default: state_d = frg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    cmd_o.div_src = frg_pkg::SRC_EUCLID;
    busy    = 1'b1;
    valid_o = 1'b0;
    unique case (state_q)
      frg_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      frg_pkg::ST_CHECK: begin
        if (!status_i.both_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = status_i.b_zero ? frg_pkg::SRC_NUMER : frg_pkg::SRC_EUCLID;
        end
      end
      frg_pkg::ST_EUC_RUN: begin
        cmd_o.step = status_i.div_done;
      end
      frg_pkg::ST_NUM_RUN: begin
        cmd_o.store_qn  = status_i.div_done;
        cmd_o.div_start = status_i.div_done;
        cmd_o.div_src   = frg_pkg::SRC_DENOM;
      end
      frg_pkg::ST_DEN_RUN: begin
        cmd_o.store_qd = status_i.div_done;
      end
      frg_pkg::ST_DONE: begin
        valid_o = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_valid_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy)
    else $error("result strobe not followed by idle");

  a_step_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> status_i.div_done)
    else $error("euclid step without divider result");

  a_load_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == frg_pkg::ST_CHECK))
    else $error("load did not enter check state");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == frg_pkg::ST_DEN_RUN) ||
                ($past(state_q) == frg_pkg::ST_CHECK))
    else $error("result strobe from unexpected state");

endmodule

`default_nettype wire

@@ src/fraction_reduce_gcd.sv @@
// fraction_reduce_gcd: top level of the fraction reducer
// depends on frg_pkg, frg_ctrl, frg_dp (and frg_div below it)
//
// usage:
//   a request is taken at a rising edge with start high and busy low;
//   numer_in_i and denom_in_i are sampled at that edge
//   the result appears on numer_out_o, denom_out_o and zero_over_zero_o
//   for exactly one cycle with valid_o high; the receiver cannot stall
//   busy stays high from the accepted request until the strobe cycle ends
// timing:
//   one shared restoring divider, one quotient bit per cycle, does every
//   remainder and both final quotients, one use after another, so the
//   time to the strobe grows with the number k of euclid steps,
//   k up to about 46 at 32 bits;
//   zero over zero goes from the check state straight to the strobe
//   one request at a time; the next is taken the cycle after the strobe
// reset:
//   rst_ni low clears the sequencer to idle; any request in flight is lost
`default_nettype none

module fraction_reduce_gcd (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire frg_pkg::word_t numer_in_i,
  input  wire frg_pkg::word_t denom_in_i,
  output logic                valid_o,
  output frg_pkg::word_t      numer_out_o,
  output frg_pkg::word_t      denom_out_o,
  output logic                zero_over_zero_o
);

  frg_pkg::cmd_t    cmd;
  frg_pkg::status_t status;

  frg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .valid_o  (valid_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  frg_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .numer_in_i       (numer_in_i),
    .denom_in_i       (denom_in_i),
    .status_o         (status),
    .numer_out_o      (numer_out_o),
    .denom_out_o      (denom_out_o),
    .zero_over_zero_o (zero_over_zero_o)
  );

endmodule

`default_nettype wire
